// File: rtl/one_line_pulse_width_command_tx_defines.svh
// Assertion macros used by the frame sequencer of the command transmitter RTL.
`ifndef ONE_LINE_PULSE_WIDTH_COMMAND_TX_DEFINES_SVH
`define ONE_LINE_PULSE_WIDTH_COMMAND_TX_DEFINES_SVH

`ifndef SYNTHESIS

// Expression must hold on every clock edge out of reset.
`define OLPW_ASSERT_ALWAYS(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("olpw assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define OLPW_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("olpw assertion failed");

`else

`define OLPW_ASSERT_ALWAYS(label, clk, rst_n, expr)
`define OLPW_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: rtl/olpw_pkg.sv
// Shared types and constants of the pulse-width command transmitter.
`timescale 1ns / 1ps
`default_nettype none

package olpw_pkg;

    localparam int DATA_BITS_DEFAULT = 8;

    localparam int CMD_W  = 2;
    localparam int BYTE_W = 8;
    localparam int REG_IDX_W = 1;

    localparam logic [CMD_W-1:0] CMD_TICK   = 2'd0;
    localparam logic [CMD_W-1:0] CMD_SEND   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_VOLUME = 2'd2;

    localparam logic [REG_IDX_W-1:0] REG_VOLUME_BASE = 1'd0;
    localparam logic [REG_IDX_W-1:0] REG_VOLUME_TOP  = 1'd1;

    localparam logic [BYTE_W-1:0] VOLUME_BASE_RESET = 8'd224;
    localparam logic [BYTE_W-1:0] VOLUME_TOP_RESET  = 8'd231;

    typedef struct packed {
        logic reset_pin;
        logic data_pin;
        logic busy_res;
        logic frame_done;
        logic refused;
    } result_t;

endpackage

`default_nettype wire

// File: rtl/olpw_cfg.sv
// Volume registers and the saturated volume command byte.
`timescale 1ns / 1ps
`default_nettype none

module olpw_cfg
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                cfg_we,
    input  wire logic [olpw_pkg::REG_IDX_W-1:0]      cfg_index,
    input  wire logic [olpw_pkg::BYTE_W-1:0]         cfg_data,
    input  wire logic [olpw_pkg::BYTE_W-1:0]         level,
    output logic      [olpw_pkg::BYTE_W-1:0]         vol_byte
);

    logic [olpw_pkg::BYTE_W-1:0] base_reg;
    logic [olpw_pkg::BYTE_W-1:0] top_reg;
    logic [olpw_pkg::BYTE_W:0]   sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg <= olpw_pkg::VOLUME_BASE_RESET;
            top_reg  <= olpw_pkg::VOLUME_TOP_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                olpw_pkg::REG_VOLUME_BASE: base_reg <= cfg_data;
                olpw_pkg::REG_VOLUME_TOP:  top_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // 9-bit sum never wraps; anything past top clamps to top.
    always_comb
    begin
        sum = {1'b0, base_reg} + {1'b0, level};
        if (sum > {1'b0, top_reg})
            vol_byte = top_reg;
        else
            vol_byte = sum[olpw_pkg::BYTE_W-1:0];
    end

endmodule

`default_nettype wire

// File: rtl/olpw_frame.sv
// Frame sequencer: phase state, bit shifter and registered result.
`timescale 1ns / 1ps
`default_nettype none
`include "one_line_pulse_width_command_tx_defines.svh"

module olpw_frame
#(
    parameter int DATA_BITS = olpw_pkg::DATA_BITS_DEFAULT
)
(
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            advance,
    input  wire logic [olpw_pkg::CMD_W-1:0]      cmd,
    input  wire logic [olpw_pkg::BYTE_W-1:0]     data_byte,
    input  wire logic [olpw_pkg::BYTE_W-1:0]     vol_byte,
    output olpw_pkg::result_t                    res
);

    localparam int BIT_W = (DATA_BITS > 1) ? $clog2(DATA_BITS) : 1;
    localparam logic [BIT_W-1:0] LAST_BIT = BIT_W'(DATA_BITS - 1);

    localparam logic [2:0] LEN_LONG  = 3'd5;
    localparam logic [2:0] LEN_WIDE  = 3'd3;
    localparam logic [2:0] LEN_SHORT = 3'd1;

    typedef enum logic [2:0] {
        PH_IDLE,
        PH_RST_LO,
        PH_RST_HI,
        PH_DAT_LO,
        PH_BIT_HI,
        PH_BIT_LO,
        PH_END
    } phase_t;

    phase_t                      phase_reg, phase_next, cur_phase;
    logic [2:0]                  tick_reg, tick_next, cur_tick, tick_inc, len;
    logic [BIT_W-1:0]            bit_reg, bit_next, cur_bit;
    logic [olpw_pkg::BYTE_W-1:0] shift_reg, shift_next, cur_shift, load_byte;
    olpw_pkg::result_t           res_reg, res_next;
    logic                        send, start;

    always_comb
    begin
        send      = cmd inside {olpw_pkg::CMD_SEND, olpw_pkg::CMD_VOLUME};
        start     = send && (phase_reg == PH_IDLE);
        load_byte = (cmd == olpw_pkg::CMD_VOLUME) ? vol_byte : data_byte;

        // a starting send is itself the first tick of the frame
        cur_phase = start ? PH_RST_LO : phase_reg;
        cur_tick  = start ? 3'd0 : tick_reg;
        cur_bit   = start ? '0 : bit_reg;
        cur_shift = start ? load_byte : shift_reg;

        case (cur_phase)
            PH_RST_LO, PH_RST_HI, PH_DAT_LO: len = LEN_LONG;
            PH_BIT_HI: len = cur_shift[0] ? LEN_WIDE : LEN_SHORT;
            PH_BIT_LO: len = cur_shift[0] ? LEN_SHORT : LEN_WIDE;
            default:   len = LEN_SHORT;
        endcase

        tick_inc   = cur_tick + 3'd1;
        phase_next = cur_phase;
        tick_next  = tick_inc;
        bit_next   = cur_bit;
        shift_next = cur_shift;

        res_next.reset_pin  = 1'b1;
        res_next.data_pin   = 1'b1;
        res_next.busy_res   = 1'b0;
        res_next.frame_done = 1'b0;
        res_next.refused    = send && !start;

        if (cur_phase == PH_IDLE)
        begin
            tick_next = cur_tick;
        end
        else
        begin
            res_next.busy_res  = 1'b1;
            res_next.reset_pin = (cur_phase != PH_RST_LO);
            res_next.data_pin  = !((cur_phase == PH_DAT_LO) || (cur_phase == PH_BIT_LO));
            if (tick_inc >= len)
            begin
                tick_next = 3'd0;
                case (cur_phase)
                    PH_RST_LO: phase_next = PH_RST_HI;
                    PH_RST_HI: phase_next = PH_DAT_LO;
                    PH_DAT_LO: phase_next = PH_BIT_HI;
                    PH_BIT_HI: phase_next = PH_BIT_LO;
                    PH_BIT_LO:
                    begin
                        shift_next = cur_shift >> 1;
                        if (cur_bit == LAST_BIT)
                        begin
                            phase_next = PH_END;
                            bit_next   = '0;
                        end
                        else
                        begin
                            phase_next = PH_BIT_HI;
                            bit_next   = cur_bit + BIT_W'(1);
                        end
                    end
                    default:
                    begin
                        res_next.frame_done = 1'b1;
                        phase_next          = PH_IDLE;
                        bit_next            = '0;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            tick_reg  <= 3'd0;
            bit_reg   <= '0;
            shift_reg <= '0;
            res_reg   <= '{reset_pin: 1'b1, data_pin: 1'b1, default: 1'b0};
        end
        else if (advance)
        begin
            phase_reg <= phase_next;
            tick_reg  <= tick_next;
            bit_reg   <= bit_next;
            shift_reg <= shift_next;
            res_reg   <= res_next;
        end
    end

    assign res = res_reg;

    `OLPW_ASSERT_ALWAYS(a_done_in_frame, clk, rst_n, !res_reg.frame_done || res_reg.busy_res)
    `OLPW_ASSERT_ALWAYS(a_refuse_in_frame, clk, rst_n, !res_reg.refused || res_reg.busy_res)
    `OLPW_ASSERT_ALWAYS(a_idle_pins_high, clk, rst_n,
        res_reg.busy_res || (res_reg.reset_pin && res_reg.data_pin))
    `OLPW_ASSERT_NEXT(a_start_enters_reset, clk, rst_n, advance && start,
        (phase_reg == PH_RST_HI) || (phase_reg == PH_RST_LO))

endmodule

`default_nettype wire

// File: rtl/one_line_pulse_width_command_tx.sv
// Top level of the one-line pulse-width command transmitter.
// Each input beat is one millisecond tick of the command line; a send beat
// (raw byte or volume level) while idle opens a frame and is its first tick,
// a send beat during a frame is dropped and flagged as refused. One result
// beat comes out per input beat with the pin levels of that tick. Throughput
// is one beat per cycle while m_tready keeps the result side free; the only
// stages are an input register and the frame sequencer's result register.
`timescale 1ns / 1ps
`default_nettype none

module one_line_pulse_width_command_tx
#(
    parameter int DATA_BITS = olpw_pkg::DATA_BITS_DEFAULT
)
(
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               s_tvalid,
    output logic                                    s_tready,
    input  wire logic [7:0]                         s_tdata,  // [7:0] data_byte
    input  wire logic [1:0]                         s_tuser,  // [1:0] cmd
    output logic                                    m_tvalid,
    input  wire logic                               m_tready,
    // [0] reset_pin, [1] data_pin, [2] busy_res, [3] refused, [7:4] zero
    output logic [7:0]                              m_tdata,
    output logic                                    m_tlast,  // frame_done
    input  wire logic                               cfg_we,
    input  wire logic [olpw_pkg::REG_IDX_W-1:0]     cfg_index,
    input  wire logic [olpw_pkg::BYTE_W-1:0]        cfg_data
);

    logic                          in_valid_reg, in_valid_next;
    logic [olpw_pkg::CMD_W-1:0]    in_cmd_reg;
    logic [olpw_pkg::BYTE_W-1:0]   in_data_reg;
    logic                          out_valid_reg, out_valid_next;
    logic                          out_free, advance, in_take;
    logic [olpw_pkg::BYTE_W-1:0]   vol_byte;
    olpw_pkg::result_t             res;

    assign out_free = !out_valid_reg || m_tready;
    assign advance  = in_valid_reg && out_free;
    assign s_tready = !in_valid_reg || advance;
    assign in_take  = s_tvalid && s_tready;

    assign in_valid_next  = in_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_cmd_reg  <= s_tuser;
            in_data_reg <= s_tdata;
        end
    end

    olpw_cfg u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .level     (in_data_reg),
        .vol_byte  (vol_byte)
    );

    olpw_frame #(
        .DATA_BITS (DATA_BITS)
    ) u_frame
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .advance   (advance),
        .cmd       (in_cmd_reg),
        .data_byte (in_data_reg),
        .vol_byte  (vol_byte),
        .res       (res)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {4'b0000, res.refused, res.busy_res, res.data_pin, res.reset_pin};
    assign m_tlast  = res.frame_done;

endmodule

`default_nettype wire

// File: bench/tb_one_line_pulse_width_command_tx.sv
// Self-checking testbench for the one-line pulse-width command transmitter.
`timescale 1ns / 1ps

module tb_one_line_pulse_width_command_tx;

    localparam int FRAME_BITS = olpw_pkg::DATA_BITS_DEFAULT;
    localparam int CYCLE_LIMIT = 400000;
    localparam int MAX_WAIT = 12;
    localparam logic [olpw_pkg::CMD_W-1:0] CMD_SPARE = 2'd3;

    typedef enum logic [2:0] {
        LINE_IDLE,
        LINE_RST_LO,
        LINE_RST_HI,
        LINE_DAT_LO,
        LINE_BIT_HI,
        LINE_BIT_LO,
        LINE_END
    } line_phase_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic s_tvalid = 1'b0;
    logic s_tready;
    logic [7:0] s_tdata = '0;      // [7:0] data_byte
    logic [1:0] s_tuser = '0;      // [1:0] cmd
    logic m_tvalid;
    logic m_tready = 1'b0;
    logic [7:0] m_tdata;           // [0] reset_pin, [1] data_pin, [2] busy_res, [3] refused
    logic m_tlast;                 // frame_done
    logic cfg_we = 1'b0;
    logic [olpw_pkg::REG_IDX_W-1:0] cfg_index = '0;
    logic [olpw_pkg::BYTE_W-1:0] cfg_data = '0;

    // line model state
    line_phase_t line_phase = LINE_IDLE;
    int ticks_in_phase = 0;
    int bits_sent = 0;
    logic [7:0] pending_bits = '0;
    logic rst_level = 1'b1;
    logic dat_level = 1'b1;
    logic [7:0] vol_base = olpw_pkg::VOLUME_BASE_RESET;
    logic [7:0] vol_top = olpw_pkg::VOLUME_TOP_RESET;

    olpw_pkg::result_t expected_pins[$];
    bit idle_on = 1'b1;
    int errors = 0;
    int cycles = 0;
    int beats_sent = 0;
    int frames_done = 0;
    int refusals = 0;
    int volume_frames = 0;

    one_line_pulse_width_command_tx #(.DATA_BITS(FRAME_BITS)) dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tlast(m_tlast),
        .cfg_we(cfg_we),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout with %0d results outstanding", $time, expected_pins.size());
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // One tick of the command line: pin levels and status for this beat.
    function automatic olpw_pkg::result_t predict_pin_levels(input logic [1:0] cmd,
                                                             input logic [7:0] data);
        olpw_pkg::result_t r;
        logic [8:0] sum;
        logic is_send;
        int span;
        r = '0;
        is_send = (cmd == olpw_pkg::CMD_SEND) || (cmd == olpw_pkg::CMD_VOLUME);
        if (is_send && line_phase != LINE_IDLE)
        begin
            r.refused = 1'b1;
        end
        else if (is_send)
        begin
            if (cmd == olpw_pkg::CMD_VOLUME)
            begin
                sum = {1'b0, vol_base} + {1'b0, data};
                pending_bits = (sum > {1'b0, vol_top}) ? vol_top : sum[7:0];
                volume_frames++;
            end
            else
            begin
                pending_bits = data;
            end
            bits_sent = 0;
            ticks_in_phase = 0;
            line_phase = LINE_RST_LO;
        end

        if (line_phase != LINE_IDLE)
        begin
            r.busy_res = 1'b1;
            rst_level = (line_phase == LINE_RST_LO) ? 1'b0 : 1'b1;
            dat_level = (line_phase == LINE_DAT_LO || line_phase == LINE_BIT_LO) ? 1'b0 : 1'b1;
            r.reset_pin = rst_level;
            r.data_pin = dat_level;
            ticks_in_phase++;
            case (line_phase)
                LINE_RST_LO, LINE_RST_HI, LINE_DAT_LO: span = 5;
                LINE_BIT_HI: span = pending_bits[0] ? 3 : 1;
                LINE_BIT_LO: span = pending_bits[0] ? 1 : 3;
                default: span = 1;
            endcase
            if (ticks_in_phase >= span)
            begin
                ticks_in_phase = 0;
                case (line_phase)
                    LINE_RST_LO: line_phase = LINE_RST_HI;
                    LINE_RST_HI: line_phase = LINE_DAT_LO;
                    LINE_DAT_LO: line_phase = LINE_BIT_HI;
                    LINE_BIT_HI: line_phase = LINE_BIT_LO;
                    LINE_BIT_LO:
                    begin
                        pending_bits = pending_bits >> 1;
                        bits_sent++;
                        line_phase = (bits_sent >= FRAME_BITS) ? LINE_END : LINE_BIT_HI;
                    end
                    default:
                    begin
                        r.frame_done = 1'b1;
                        line_phase = LINE_IDLE;
                        bits_sent = 0;
                        rst_level = 1'b1;
                        dat_level = 1'b1;
                    end
                endcase
            end
        end
        else
        begin
            r.reset_pin = rst_level;
            r.data_pin = dat_level;
        end
        return r;
    endfunction

    // Called at a rising edge; returns at the edge where the beat is taken.
    task automatic send_beat(input logic [1:0] cmd, input logic [7:0] data);
        int gap;
        olpw_pkg::result_t r;
        gap = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser <= cmd;
        s_tdata <= data;
        do
            @(posedge clk);
        while (!s_tready);
        r = predict_pin_levels(cmd, data);
        expected_pins.push_back(r);
        beats_sent++;
        if (r.frame_done)
            frames_done++;
        if (r.refused)
            refusals++;
    endtask

    task automatic send_tick();
        send_beat(($urandom_range(0, 3) == 0) ? CMD_SPARE : olpw_pkg::CMD_TICK, 8'($urandom));
    endtask

    // Run ticks until the frame in flight is over; optionally hit its last tick with a send.
    task automatic finish_frame(input bit refuse_on_last);
        while (line_phase != LINE_IDLE)
        begin
            if (refuse_on_last && line_phase == LINE_END)
                send_beat($urandom_range(0, 1) ? olpw_pkg::CMD_SEND : olpw_pkg::CMD_VOLUME,
                          8'($urandom));
            else
                send_tick();
        end
    endtask

    task automatic quiesce();
        s_tvalid <= 1'b0;
        while (expected_pins.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [olpw_pkg::REG_IDX_W-1:0] idx,
                             input logic [7:0] value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
        if (idx == olpw_pkg::REG_VOLUME_BASE)
            vol_base = value;
        else
            vol_top = value;
    endtask

    task automatic check_field(input string name, input logic [7:0] exp_v, input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            $display("%0t: %s expected %0h actual %0h", $time, name, exp_v, act_v);
        end
    endtask

    always @(posedge clk)
    begin
        olpw_pkg::result_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_pins.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected beat, expected none actual data %0h last %0b",
                         $time, m_tdata, m_tlast);
            end
            else
            begin
                e = expected_pins.pop_front();
                check_field("reset_pin", 8'(e.reset_pin), 8'(m_tdata[0]));
                check_field("data_pin", 8'(e.data_pin), 8'(m_tdata[1]));
                check_field("busy_res", 8'(e.busy_res), 8'(m_tdata[2]));
                check_field("refused", 8'(e.refused), 8'(m_tdata[3]));
                check_field("pad", 8'h00, 8'(m_tdata[7:4]));
                check_field("frame_done", 8'(e.frame_done), 8'(m_tlast));
            end
        end
    end

    // result side back-pressure
    initial
    begin
        int stall;
        @(posedge rst_n);
        forever
        begin
            stall = idle_on ? $urandom_range(0, MAX_WAIT) : 0;
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do
                @(posedge clk);
            while (!m_tvalid);
        end
    end

    task automatic test_idle_ticks();
        send_beat(olpw_pkg::CMD_TICK, 8'h00);
        send_beat(CMD_SPARE, 8'hFF);
        send_beat(olpw_pkg::CMD_TICK, 8'hFF);
        send_beat(CMD_SPARE, 8'h00);
        quiesce();
    endtask

    // all-ones and all-zeros bytes, sends while busy, send on the final tick
    task automatic test_raw_frames();
        send_beat(olpw_pkg::CMD_SEND, 8'hFF);
        send_beat(olpw_pkg::CMD_VOLUME, 8'h00);
        send_beat(olpw_pkg::CMD_SEND, 8'h00);
        finish_frame(1'b1);
        send_beat(olpw_pkg::CMD_SEND, 8'h00);
        finish_frame(1'b0);
        quiesce();
    endtask

    // volume at reset registers, then register extremes, base above top included
    task automatic test_volume_saturation();
        send_beat(olpw_pkg::CMD_VOLUME, 8'h03);
        finish_frame(1'b0);
        send_beat(olpw_pkg::CMD_VOLUME, 8'hFF);
        finish_frame(1'b0);
        quiesce();
        write_reg(olpw_pkg::REG_VOLUME_BASE, 8'h00);
        write_reg(olpw_pkg::REG_VOLUME_TOP, 8'hFF);
        send_beat(olpw_pkg::CMD_VOLUME, 8'hFF);
        finish_frame(1'b0);
        quiesce();
        write_reg(olpw_pkg::REG_VOLUME_BASE, 8'hFF);
        write_reg(olpw_pkg::REG_VOLUME_TOP, 8'h00);
        send_beat(olpw_pkg::CMD_VOLUME, 8'h00);
        finish_frame(1'b0);
        quiesce();
        write_reg(olpw_pkg::REG_VOLUME_TOP, 8'hFF);
        send_beat(olpw_pkg::CMD_VOLUME, 8'hFF);
        finish_frame(1'b0);
        quiesce();
    endtask

    function automatic logic [7:0] pick_reg_value();
        case ($urandom_range(0, 3))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    task automatic test_random_traffic();
        int r;
        for (int setting = 0; setting < 5; setting++)
        begin
            write_reg(olpw_pkg::REG_VOLUME_BASE, pick_reg_value());
            write_reg(olpw_pkg::REG_VOLUME_TOP, pick_reg_value());
            for (int n = 0; n < 80; n++)
            begin
                if (n % 40 == 0)
                    idle_on = ($urandom_range(0, 3) != 0);
                r = $urandom_range(0, 99);
                if (r < 70)
                    send_beat(olpw_pkg::CMD_TICK, 8'($urandom));
                else if (r < 78)
                    send_beat(CMD_SPARE, 8'($urandom));
                else if (r < 90)
                    send_beat(olpw_pkg::CMD_SEND, 8'($urandom));
                else
                    send_beat(olpw_pkg::CMD_VOLUME, 8'($urandom));
            end
            idle_on = 1'b1;
            finish_frame(1'($urandom_range(0, 1)));
            quiesce();
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        test_idle_ticks();
        test_raw_frames();
        test_volume_saturation();
        test_random_traffic();

        quiesce();
        repeat (8) @(posedge clk);
        $display("%0d beats, %0d frames (%0d volume), %0d refused sends",
                 beats_sent, frames_done, volume_frames, refusals);
        $display("register settings included zero, full scale and base above top");
        if (errors == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl
rtl/olpw_pkg.sv
rtl/olpw_cfg.sv
rtl/olpw_frame.sv
rtl/one_line_pulse_width_command_tx.sv
bench/tb_one_line_pulse_width_command_tx.sv
